>>> rtl/pgst_pkg.sv
// Package for the PID gaze servo tracker: widths, reset values, register
// indexes, controller states and controller-to-datapath command types.
// No dependencies.
`default_nettype none

package pgst_pkg;

    localparam int ImageWidth  = 640;
    localparam int ImageHeight = 480;

    localparam int GainW    = 16;
    localparam int ServoW   = 12;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int ErrW     = 12;
    localparam int OffW     = 24;
    localparam int IntegW   = 32;
    localparam int DiffW    = 25;
    localparam int MulAW    = 33;
    localparam int MulBW    = 17;
    localparam int ProdW    = MulAW + MulBW;
    localparam int TotW     = ProdW + 1;
    localparam int FracW    = 24;
    localparam int PosW     = TotW - FracW;

    localparam logic [ErrW-1:0] XCentre = ErrW'(ImageWidth / 2);
    localparam logic [ErrW-1:0] YCentre = ErrW'(ImageHeight / 2);

    localparam logic [GainW-1:0]  GainPropRst  = 16'd3277;
    localparam logic [GainW-1:0]  GainIntegRst = 16'd66;
    localparam logic [GainW-1:0]  GainDerivRst = 16'd655;
    localparam logic [GainW-1:0]  ScaleRst     = 16'd256;
    localparam logic [ServoW-1:0] ServoLowRst  = 12'd1000;
    localparam logic [ServoW-1:0] ServoHighRst = 12'd2000;
    localparam logic [ServoW-1:0] ServoCtrRst  = 12'd1500;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN_PROP    = 3'd0,
        CFG_GAIN_INTEG   = 3'd1,
        CFG_GAIN_DERIV   = 3'd2,
        CFG_X_SCALE      = 3'd3,
        CFG_Y_SCALE      = 3'd4,
        CFG_SERVO_LOW    = 3'd5,
        CFG_SERVO_HIGH   = 3'd6,
        CFG_SERVO_CENTRE = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFF,
        ST_INTEG,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_SUM,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        MUL_OFF,
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        t_mul_op mul_op;
        logic    integ_en;
        t_acc_op acc_op;
        logic    fin_en;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/pgst_in_if.sv
// Input channel of the PID gaze servo tracker: valid/ready and one update
// request (axis, match position, template size). No dependencies.
`default_nettype none

interface pgst_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] axis_sel;
    logic [9:0] match_pos;
    logic [8:0] tmpl_size;

    modport source (output valid, output axis_sel, output match_pos, output tmpl_size,
                    input ready);
    modport sink   (input valid, input axis_sel, input match_pos, input tmpl_size,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pgst_out_if.sv
// Output channel of the PID gaze servo tracker: valid/ready and one servo
// command (axis, position, clamp flag). No dependencies.
`default_nettype none

interface pgst_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  axis_out;
    logic [11:0] servo_pos;
    logic        clamped;

    modport source (output valid, output axis_out, output servo_pos, output clamped,
                    input ready);
    modport sink   (input valid, input axis_out, input servo_pos, input clamped,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pgst_ctrl.sv
// Controller of the PID gaze servo tracker: sequences one update through
// the shared multiplier and accumulator. Depends on pgst_pkg.
`default_nettype none

module pgst_ctrl import pgst_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.mul_op = MUL_OFF;
        o_cmd.acc_op = ACC_HOLD;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_OFF;
                end
            end
            ST_OFF: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_OFF;
                n_state      = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.integ_en = 1'b1;
                n_state        = ST_MP;
            end
            ST_MP: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_P;
                n_state      = ST_MI;
            end
            ST_MI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_I;
                o_cmd.acc_op = ACC_LOAD;
                n_state      = ST_MD;
            end
            ST_MD: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_D;
                o_cmd.acc_op = ACC_ADD;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.acc_op = ACC_SUB;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin_en = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/pgst_dp.sv
// Datapath of the PID gaze servo tracker: configuration registers, per-axis
// state, shared multiplier, accumulator, clamp and output register.
// Depends on pgst_pkg.
`default_nettype none

module pgst_dp import pgst_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic [1:0]          i_axis_sel,
    input  wire logic [9:0]          i_match_pos,
    input  wire logic [8:0]          i_tmpl_size,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_status               o_status,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_axis_out,
    output logic [ServoW-1:0]        o_servo_pos,
    output logic                     o_clamped
);

    logic [GainW-1:0]  r_gain_prop;
    logic [GainW-1:0]  r_gain_integ;
    logic [GainW-1:0]  r_gain_deriv;
    logic [GainW-1:0]  r_x_scale;
    logic [GainW-1:0]  r_y_scale;
    logic [ServoW-1:0] r_servo_low;
    logic [ServoW-1:0] r_servo_high;

    logic [IntegW-1:0] r_integ_sum [4];
    logic [OffW-1:0]   r_prev_off  [4];
    logic [ServoW-1:0] r_servo_now [4];

    logic [1:0]        r_axis;
    logic [9:0]        r_pos;
    logic [7:0]        r_half;
    logic [ProdW-1:0]  r_prod;
    logic [OffW-1:0]   r_off;
    logic [IntegW-1:0] r_integ;
    logic [DiffW-1:0]  r_diff;
    logic [ProdW-1:0]  r_acc;
    logic [ProdW-1:0]  n_acc;

    logic              r_out_valid;
    logic [1:0]        r_out_axis;
    logic [ServoW-1:0] r_out_pos;
    logic              r_out_clamped;

    logic                     w_is_y;
    logic signed [ErrW-1:0]   w_err;
    logic signed [MulAW-1:0]  w_mul_a;
    logic signed [MulBW-1:0]  w_mul_b;
    logic signed [ProdW-1:0]  w_mul_p;
    logic                     w_off_ovf;
    logic [OffW-1:0]          w_off;
    logic [IntegW-1:0]        w_integ_old;
    logic [IntegW:0]          w_isum;
    logic [IntegW-1:0]        w_integ;
    logic [DiffW-1:0]         w_diff;
    logic signed [TotW-1:0]   w_base;
    logic signed [TotW-1:0]   w_acc_ext;
    logic signed [TotW-1:0]   w_tot;
    logic signed [TotW-1:0]   w_tot_adj;
    logic signed [PosW-1:0]   w_np;
    logic signed [PosW-1:0]   w_hi;
    logic signed [PosW-1:0]   w_lo;
    logic signed [PosW-1:0]   w_lim_hi;
    logic signed [PosW-1:0]   w_lim;
    logic                     w_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= GainPropRst;
            r_gain_integ <= GainIntegRst;
            r_gain_deriv <= GainDerivRst;
            r_x_scale    <= ScaleRst;
            r_y_scale    <= ScaleRst;
            r_servo_low  <= ServoLowRst;
            r_servo_high <= ServoHighRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_PROP:  r_gain_prop  <= i_cfg_data;
                CFG_GAIN_INTEG: r_gain_integ <= i_cfg_data;
                CFG_GAIN_DERIV: r_gain_deriv <= i_cfg_data;
                CFG_X_SCALE:    r_x_scale    <= i_cfg_data;
                CFG_Y_SCALE:    r_y_scale    <= i_cfg_data;
                CFG_SERVO_LOW:  r_servo_low  <= i_cfg_data[ServoW-1:0];
                CFG_SERVO_HIGH: r_servo_high <= i_cfg_data[ServoW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_is_y = r_axis[0];

    always_comb begin
        w_err = $signed({2'b00, r_pos}) + $signed({4'b0000, r_half})
              - $signed(w_is_y ? YCentre : XCentre);
        case (i_cmd.mul_op)
            MUL_OFF: begin
                w_mul_a = MulAW'(w_err);
                w_mul_b = $signed({1'b0, (w_is_y ? r_y_scale : r_x_scale)});
            end
            MUL_P: begin
                w_mul_a = MulAW'($signed(r_off));
                w_mul_b = $signed({1'b0, r_gain_prop});
            end
            MUL_I: begin
                w_mul_a = MulAW'($signed(r_integ));
                w_mul_b = $signed({1'b0, r_gain_integ});
            end
            MUL_D: begin
                w_mul_a = MulAW'($signed(r_diff));
                w_mul_b = $signed({1'b0, r_gain_deriv});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    always_comb begin
        w_off_ovf   = (r_prod[ProdW-1:OffW-1] != {(ProdW-OffW+1){r_prod[ProdW-1]}});
        if (w_off_ovf) begin
            w_off = r_prod[ProdW-1] ? {1'b1, {(OffW-1){1'b0}}} : {1'b0, {(OffW-1){1'b1}}};
        end else begin
            w_off = r_prod[OffW-1:0];
        end
        w_integ_old = r_integ_sum[r_axis];
        w_isum      = {w_integ_old[IntegW-1], w_integ_old}
                    + {{(IntegW-OffW+1){w_off[OffW-1]}}, w_off};
        if (w_isum[IntegW] != w_isum[IntegW-1]) begin
            w_integ = w_isum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                     : {1'b0, {(IntegW-1){1'b1}}};
        end else begin
            w_integ = w_isum[IntegW-1:0];
        end
        w_diff = {w_off[OffW-1], w_off} - {r_prev_off[r_axis][OffW-1], r_prev_off[r_axis]};
    end

    always_comb begin
        case (i_cmd.acc_op)
            ACC_LOAD: n_acc = r_prod;
            ACC_ADD:  n_acc = r_acc + r_prod;
            ACC_SUB:  n_acc = r_acc - r_prod;
            default:  n_acc = r_acc;
        endcase
    end

    always_comb begin
        w_base    = $signed({{(TotW-ServoW-FracW){1'b0}}, r_servo_now[r_axis],
                             {FracW{1'b0}}});
        w_acc_ext = TotW'($signed(r_acc));
        w_tot     = w_is_y ? (w_base - w_acc_ext) : (w_base + w_acc_ext);
        w_tot_adj = w_tot + (w_tot[TotW-1] ? TotW'({FracW{1'b1}}) : TotW'(0));
        w_np      = w_tot_adj[TotW-1:FracW];
        w_hi      = $signed({{(PosW-ServoW){1'b0}}, r_servo_high});
        w_lo      = $signed({{(PosW-ServoW){1'b0}}, r_servo_low});
        w_lim_hi  = (w_np > w_hi) ? w_hi : w_np;
        w_lim     = (w_lim_hi < w_lo) ? w_lo : w_lim_hi;
        w_clamped = (w_lim != w_np);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_axis <= i_axis_sel;
            r_pos  <= i_match_pos;
            r_half <= i_tmpl_size[8:1];
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul_p;
        end
        if (i_cmd.integ_en) begin
            r_off   <= w_off;
            r_integ <= w_integ;
            r_diff  <= w_diff;
        end
        r_acc <= n_acc;
        if (i_cmd.fin_en) begin
            r_out_axis    <= r_axis;
            r_out_pos     <= w_lim[ServoW-1:0];
            r_out_clamped <= w_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_integ_sum[i] <= '0;
                r_prev_off[i]  <= '0;
                r_servo_now[i] <= ServoCtrRst;
            end
        end else if (i_cmd.fin_en) begin
            r_integ_sum[r_axis] <= r_integ;
            r_prev_off[r_axis]  <= r_off;
            r_servo_now[r_axis] <= w_lim[ServoW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_axis_out        = r_out_axis;
    assign o_servo_pos       = r_out_pos;
    assign o_clamped         = r_out_clamped;

endmodule

`default_nettype wire

>>> rtl/pid_gaze_servo_tracker.sv
// PID gaze servo tracker: per-axis PID update of four eye servos.
// One multiplier is shared by the offset, P, I and D products in sequence.
// A new request is taken only once the last update has been written to the
// output register; the output register frees the input while a result
// waits. Synchronous active-low reset restores the default registers,
// clears integrals and previous offsets, and centres all servos.
`default_nettype none

module pid_gaze_servo_tracker import pgst_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    pgst_in_if.sink                  i_req,
    pgst_out_if.source               o_rsp
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_req.ready = w_in_ready;

    pgst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pgst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_axis_sel  (i_req.axis_sel),
        .i_match_pos (i_req.match_pos),
        .i_tmpl_size (i_req.tmpl_size),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_axis_out  (o_rsp.axis_out),
        .o_servo_pos (o_rsp.servo_pos),
        .o_clamped   (o_rsp.clamped)
    );

    a_fin_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin_en |-> w_status.out_free)
        else $error("result written while output register still full");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("input ready right after a transfer");

    a_fin_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin_en |=> o_rsp.valid)
        else $error("finished update did not reach the output");

endmodule

`default_nettype wire
